### hw/rtl/sal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_pkg
// Shared types and constants of the set-associative LRU cache model: access
// codes, register indexes, field widths, sequencer states and compare result.
// ----------------------------------------------------------------------------
package sal_pkg;

   localparam int OPCODE_W      = 2;
   localparam int COUNT_W       = 32;
   localparam int STAMP_W       = 64;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 5;
   localparam int SET_BITS_W    = 3;
   localparam int OFFSET_BITS_W = 5;
   localparam int WAYS_W        = 4;
   localparam int RSP_FIELDS_W  = 2 + 1 + 1 + 3 * COUNT_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_MODIFY = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_NOP    = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS        = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic hit;
      logic older;
   } cmp_res_type;

endpackage

### hw/rtl/sal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/sal_way_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sal_way_cmp
// Shared way compare unit: tag match and LRU stamp compare for one way.
// ----------------------------------------------------------------------------
module sal_way_cmp #(
   parameter int TAG_W = 32
) (
   input  logic                         entry_valid,
   input  logic [TAG_W-1:0]             entry_tag,
   input  logic [TAG_W-1:0]             lookup_tag,
   input  logic [sal_pkg::STAMP_W-1:0]  entry_stamp,
   input  logic [sal_pkg::STAMP_W-1:0]  best_stamp,
   output sal_pkg::cmp_res_type         result
);
   import sal_pkg::*;

   always_comb begin
      result.hit   = entry_valid && (entry_tag == lookup_tag);
      result.older = entry_valid && (entry_stamp < best_stamp);
   end

endmodule

### hw/rtl/set_assoc_lru_cache_model_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_unit
// Tag-only set-associative cache model with LRU replacement and hit, miss
// and eviction counters.
// ----------------------------------------------------------------------------
// Each item is one access (load, store, modify or no-op code) and gives one
// result item. The set row is read from a RAM in the accept cycle, then one
// way compare unit walks the ways one per cycle until a hit or the last way
// in use, and a final state writes the row back and loads the result. The
// ways in use are the configured count, with zero read as one and values
// above MAX_WAYS read as MAX_WAYS. A modify scans like a load; the no-op code
// skips the scan and the row write. The final state is held for as long as
// the previous result still waits unaccepted on the rsp side. After reset a
// clearing pass empties the tag RAM before the first item is taken.
// A new item can be taken while a result still waits on the rsp side.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_unit #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_BITS    = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((ADDR_BITS + 7) / 8) * 8-1:0]   req_tdata,  // address
   input  logic [sal_pkg::OPCODE_W-1:0]           req_tuser,  // opcode
   // result channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // hit_count, missed, evicted, total_hits, total_misses, total_evictions
   output logic [sal_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sal_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [sal_pkg::CSR_DATA_W-1:0]         csr_data
);
   import sal_pkg::*;

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int ENTRY_W  = 1 + ADDR_BITS + STAMP_W;
   localparam int ROW_W    = MAX_WAYS * ENTRY_W;

   // configuration
   logic [SET_BITS_W-1:0]    set_bits_ff, set_bits_in;
   logic [OFFSET_BITS_W-1:0] offset_bits_ff, offset_bits_in;
   logic [WAYS_W-1:0]        ways_ff, ways_in;

   // sequencer and access context
   state_type              state_ff, state_in;
   logic [SET_AW-1:0]      clr_ff, clr_in;
   logic [SET_AW-1:0]      set_ff, set_in;
   logic [ADDR_BITS-1:0]   tag_ff, tag_in;
   logic                   nop_ff, nop_in;
   logic                   dbl_ff, dbl_in;
   logic [WAY_W-1:0]       way_ff, way_in;
   logic                   hit_ff, hit_in;
   logic [WAY_W-1:0]       hit_way_ff, hit_way_in;
   logic                   full_ff, full_in;
   logic [WAY_W-1:0]       empty_way_ff, empty_way_in;
   logic [WAY_W-1:0]       victim_ff, victim_in;
   logic [STAMP_W-1:0]     best_ff, best_in;

   // counters
   logic [STAMP_W-1:0]     clock_ff, clock_in;
   logic [COUNT_W-1:0]     hit_total_ff, hit_total_in;
   logic [COUNT_W-1:0]     miss_total_ff, miss_total_in;
   logic [COUNT_W-1:0]     evict_total_ff, evict_total_in;

   // result slot
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_hits_ff, rsp_hits_in;
   logic                   rsp_missed_ff, rsp_missed_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;

   // control
   logic                   ctl_clear, ctl_ready, ctl_scan, ctl_commit;
   logic                   req_accept;

   // address decode
   logic [ADDR_BITS-1:0]   req_addr;
   logic [3:0]             eff_set_bits;
   logic [5:0]             tag_shift;
   logic [SET_AW-1:0]      set_mask;
   logic [3:0]             eff_ways;
   logic [WAY_W-1:0]       last_way;

   // row access
   logic [ROW_W-1:0]                       rd_data;
   logic [MAX_WAYS-1:0][ENTRY_W-1:0]       rd_row;
   logic [MAX_WAYS-1:0][ENTRY_W-1:0]       wr_row;
   logic [ENTRY_W-1:0]                     cur_entry;
   logic                                   cur_valid;
   logic [ADDR_BITS-1:0]                   cur_tag;
   logic [STAMP_W-1:0]                     cur_stamp;
   logic [STAMP_W-1:0]                     best_sel;
   cmp_res_type                            cmp_res;
   logic [STAMP_W-1:0]                     new_clock;
   logic [WAY_W-1:0]                       fill_way;
   logic [ENTRY_W-1:0]                     new_entry;
   logic                                   ram_wr_en;
   logic [SET_AW-1:0]                      ram_wr_addr;
   logic [ROW_W-1:0]                       ram_wr_data;

   assign req_addr   = req_tdata[ADDR_BITS-1:0];
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = ctl_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      eff_set_bits = (set_bits_ff > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_ff};
      tag_shift    = {1'b0, offset_bits_ff} + {2'b00, eff_set_bits};
      set_mask     = ~({SET_AW{1'b1}} << eff_set_bits);
      if (ways_ff == '0) begin
         eff_ways = 4'd1;
      end else if (ways_ff > MAX_WAYS) begin
         eff_ways = 4'(MAX_WAYS);
      end else begin
         eff_ways = ways_ff;
      end
      last_way = WAY_W'(eff_ways - 4'd1);
   end

   // row memory: one row holds every way of a set
   sal_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (SET_AW'(req_addr >> offset_bits_ff) & set_mask),
      .rd_data (rd_data)
   );

   assign rd_row    = rd_data;
   assign cur_entry = rd_row[way_ff];
   assign cur_valid = cur_entry[0];
   assign cur_tag   = cur_entry[ADDR_BITS:1];
   assign cur_stamp = cur_entry[ENTRY_W-1:ADDR_BITS+1];
   // way 0 seeds the lru search with its own stamp
   assign best_sel  = (way_ff == '0) ? cur_stamp : best_ff;

   sal_way_cmp #(
      .TAG_W (ADDR_BITS)
   ) u_way_cmp (
      .entry_valid (cur_valid),
      .entry_tag   (cur_tag),
      .lookup_tag  (tag_ff),
      .entry_stamp (cur_stamp),
      .best_stamp  (best_sel),
      .result      (cmp_res)
   );

   // write-back row
   assign new_clock = clock_ff + (dbl_ff ? 64'd2 : 64'd1);
   assign fill_way  = hit_ff ? hit_way_ff : (full_ff ? victim_ff : empty_way_ff);
   assign new_entry = {new_clock, tag_ff, 1'b1};

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         wr_row[w] = (WAY_W'(w) == fill_way) ? new_entry : rd_row[w];
      end
   end

   assign ram_wr_en   = ctl_clear || (ctl_commit && !nop_ff);
   assign ram_wr_addr = ctl_clear ? clr_ff : set_ff;
   assign ram_wr_data = ctl_clear ? '0 : wr_row;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_AW'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == OP_NOP) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_res.hit || (way_ff == last_way)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (ctl_commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctl_clear  = 1'b0;
      ctl_ready  = 1'b0;
      ctl_scan   = 1'b0;
      ctl_commit = 1'b0;
      case (state_ff)
         ST_CLEAR:  ctl_clear = 1'b1;
         ST_IDLE:   ctl_ready = 1'b1;
         ST_SCAN:   ctl_scan  = 1'b1;
         ST_FINISH: ctl_commit = !rsp_valid_ff || rsp_tready;
         default:   ctl_clear = 1'b0;
      endcase
   end

   // configuration writes
   always_comb begin
      set_bits_in    = set_bits_ff;
      offset_bits_in = offset_bits_ff;
      ways_in        = ways_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_in    = csr_data[SET_BITS_W-1:0];
            CSR_OFFSET_BITS: offset_bits_in = csr_data[OFFSET_BITS_W-1:0];
            CSR_WAYS:        ways_in        = csr_data[WAYS_W-1:0];
            default:         ways_in        = ways_ff;
         endcase
      end
   end

   // datapath
   always_comb begin
      clr_in         = clr_ff;
      set_in         = set_ff;
      tag_in         = tag_ff;
      nop_in         = nop_ff;
      dbl_in         = dbl_ff;
      way_in         = way_ff;
      hit_in         = hit_ff;
      hit_way_in     = hit_way_ff;
      full_in        = full_ff;
      empty_way_in   = empty_way_ff;
      victim_in      = victim_ff;
      best_in        = best_ff;
      clock_in       = clock_ff;
      hit_total_in   = hit_total_ff;
      miss_total_in  = miss_total_ff;
      evict_total_in = evict_total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_hits_in    = rsp_hits_ff;
      rsp_missed_in  = rsp_missed_ff;
      rsp_evicted_in = rsp_evicted_ff;

      if (ctl_clear) begin
         clr_in = clr_ff + SET_AW'(1);
      end

      if (req_accept) begin
         set_in    = SET_AW'(req_addr >> offset_bits_ff) & set_mask;
         tag_in    = req_addr >> tag_shift;
         way_in    = '0;
         hit_in    = 1'b0;
         full_in   = 1'b1;
         victim_in = '0;
         case (req_tuser)
            OP_LOAD, OP_STORE: begin
               nop_in = 1'b0;
               dbl_in = 1'b0;
            end
            OP_MODIFY: begin
               nop_in = 1'b0;
               dbl_in = 1'b1;
            end
            default: begin
               nop_in = 1'b1;
               dbl_in = 1'b0;
            end
         endcase
      end

      if (ctl_scan) begin
         way_in = way_ff + WAY_W'(1);
         if (way_ff == '0) begin
            best_in = cur_stamp;
         end
         if (cmp_res.hit) begin
            hit_in     = 1'b1;
            hit_way_in = way_ff;
         end else if (cur_valid) begin
            if (cmp_res.older) begin
               victim_in = way_ff;
               best_in   = cur_stamp;
            end
         end else begin
            full_in      = 1'b0;
            empty_way_in = way_ff;
         end
      end

      if (ctl_commit) begin
         rsp_valid_in = 1'b1;
         if (nop_ff) begin
            rsp_hits_in    = 2'd0;
            rsp_missed_in  = 1'b0;
            rsp_evicted_in = 1'b0;
         end else begin
            // a modify adds a second access that always hits
            rsp_hits_in    = {1'b0, hit_ff} + {1'b0, dbl_ff};
            rsp_missed_in  = !hit_ff;
            rsp_evicted_in = !hit_ff && full_ff;
            clock_in       = new_clock;
            hit_total_in   = hit_total_ff + COUNT_W'(rsp_hits_in);
            miss_total_in  = miss_total_ff + COUNT_W'(!hit_ff);
            evict_total_in = evict_total_ff + COUNT_W'(!hit_ff && full_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         set_bits_ff    <= '0;
         offset_bits_ff <= '0;
         ways_ff        <= WAYS_W'(1);
         clock_ff       <= '0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         set_bits_ff    <= set_bits_in;
         offset_bits_ff <= offset_bits_in;
         ways_ff        <= ways_in;
         clock_ff       <= clock_in;
         hit_total_ff   <= hit_total_in;
         miss_total_ff  <= miss_total_in;
         evict_total_ff <= evict_total_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff         <= set_in;
      tag_ff         <= tag_in;
      nop_ff         <= nop_in;
      dbl_ff         <= dbl_in;
      way_ff         <= way_in;
      hit_ff         <= hit_in;
      hit_way_ff     <= hit_way_in;
      full_ff        <= full_in;
      empty_way_ff   <= empty_way_in;
      victim_ff      <= victim_in;
      best_ff        <= best_in;
      rsp_hits_ff    <= rsp_hits_in;
      rsp_missed_ff  <= rsp_missed_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   // totals only move on a commit, which needs the slot free first
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}},
                        evict_total_ff, miss_total_ff, hit_total_ff,
                        rsp_evicted_ff, rsp_missed_ff, rsp_hits_ff};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache model unit. Accesses
// are streamed in under random gaps and back-pressure. A tag/stamp shadow of
// the cache predicts each result item, which is checked field by field
// against the item that comes out. Geometry is changed between phases while
// the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import sal_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int SET_LIMIT    = 6;
   localparam int WAY_LIMIT    = 8;
   localparam int ADDR_W       = 32;
   localparam int NUM_SETS     = 1 << SET_LIMIT;
   localparam int DRAIN_CYCLES = WAY_LIMIT + 4;
   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_ITEMS  = 200;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [OPCODE_W-1:0] opcode;
      logic [ADDR_W-1:0]   address;
   } access_item_t;

   typedef struct packed {
      logic [COUNT_W-1:0] evictions;
      logic [COUNT_W-1:0] misses;
      logic [COUNT_W-1:0] hits;
      logic               evicted;
      logic               missed;
      logic [1:0]         hit_count;
   } lookup_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ADDR_W-1:0]      req_tdata  = '0;
   logic [OPCODE_W-1:0]    req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   set_assoc_lru_cache_model_unit #(
      .MAX_SET_BITS(SET_LIMIT),
      .MAX_WAYS    (WAY_LIMIT),
      .ADDR_BITS   (ADDR_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // address
      .req_tuser (req_tuser),   // opcode
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      // hit_count, missed, evicted, total_hits, total_misses, total_evictions
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow cache state and geometry
   logic [SET_BITS_W-1:0]    geo_set_bits    = '0;
   logic [OFFSET_BITS_W-1:0] geo_offset_bits = '0;
   logic [WAYS_W-1:0]        geo_ways        = 4'd1;

   bit                 line_ok    [NUM_SETS][WAY_LIMIT];
   bit [63:0]          line_tag   [NUM_SETS][WAY_LIMIT];
   bit [STAMP_W-1:0]   line_stamp [NUM_SETS][WAY_LIMIT];
   bit [STAMP_W-1:0]   lru_clock;
   bit [COUNT_W-1:0]   hit_sum;
   bit [COUNT_W-1:0]   miss_sum;
   bit [COUNT_W-1:0]   evict_sum;

   access_item_t   pending_accesses[$];
   lookup_result_t expected_lookups[$];

   int idle_pct    = 37;
   int mismatches  = 0;
   int n_checked   = 0;
   int n_sent      = 0;
   int n_settings  = 0;
   int stall_count = 0;

   function automatic int unsigned active_ways();
      if (geo_ways == 0) return 1;
      if (geo_ways > WAY_LIMIT) return WAY_LIMIT;
      return geo_ways;
   endfunction

   function automatic int unsigned active_set_bits();
      return (geo_set_bits > SET_LIMIT) ? SET_LIMIT : geo_set_bits;
   endfunction

   // one lookup and fill of a set, returns 1 on a hit
   function automatic bit probe_set(input int unsigned set_idx, input bit [63:0] tag,
                                    inout bit miss, inout bit evict);
      int unsigned ways;
      int unsigned empty_way;
      int unsigned victim;
      bit full;
      ways      = active_ways();
      full      = 1'b1;
      empty_way = 0;
      victim    = 0;
      for (int unsigned w = 0; w < ways; w++) begin
         if (line_ok[set_idx][w]) begin
            if (line_tag[set_idx][w] == tag) begin
               lru_clock++;
               line_stamp[set_idx][w] = lru_clock;
               hit_sum++;
               return 1'b1;
            end
            if (line_stamp[set_idx][w] < line_stamp[set_idx][victim]) victim = w;
         end else begin
            full      = 1'b0;
            empty_way = w;
         end
      end
      miss_sum++;
      miss = 1'b1;
      if (full) begin
         evict_sum++;
         evict = 1'b1;
      end else begin
         victim = empty_way;
      end
      lru_clock++;
      line_ok[set_idx][victim]    = 1'b1;
      line_tag[set_idx][victim]   = tag;
      line_stamp[set_idx][victim] = lru_clock;
      return 1'b0;
   endfunction

   function automatic lookup_result_t predict_lookup(input logic [OPCODE_W-1:0] op,
                                                     input logic [ADDR_W-1:0] address);
      bit [63:0] addr64;
      bit [63:0] tag;
      int unsigned sbits;
      int unsigned set_idx;
      int unsigned hits;
      bit miss;
      bit evict;
      lookup_result_t r;
      addr64  = 64'(address);
      sbits   = active_set_bits();
      set_idx = int'((addr64 >> geo_offset_bits) & ((64'd1 << sbits) - 64'd1));
      tag     = addr64 >> (geo_offset_bits + sbits);
      hits    = 0;
      miss    = 1'b0;
      evict   = 1'b0;
      if (op != OP_NOP) begin
         hits += probe_set(set_idx, tag, miss, evict);
         if (op == OP_MODIFY) hits += probe_set(set_idx, tag, miss, evict);
      end
      r.hit_count = 2'(hits);
      r.missed    = miss;
      r.evicted   = evict;
      r.hits      = hit_sum;
      r.misses    = miss_sum;
      r.evictions = evict_sum;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      access_item_t item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_lookups.push_back(predict_lookup(req_tuser, req_tdata));
            n_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_accesses.size() > 0 && $urandom_range(99) >= idle_pct) begin
               item = pending_accesses.pop_front();
               req_tuser  <= item.opcode;
               req_tdata  <= item.address;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : watch_rsp
      lookup_result_t got;
      lookup_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = lookup_result_t'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (expected_lookups.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result item: hit_count %0d missed %0b evicted %0b",
                           got.hit_count, got.missed, got.evicted);
            end else begin
               want = expected_lookups.pop_front();
               if (got.hit_count !== want.hit_count || got.missed !== want.missed ||
                   got.evicted !== want.evicted || got.hits !== want.hits ||
                   got.misses !== want.misses || got.evictions !== want.evictions) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch on result %0d: expected hc %0d m %0b e %0b totals %0d/%0d/%0d",
                              n_checked, want.hit_count, want.missed, want.evicted,
                              want.hits, want.misses, want.evictions);
                     $display("   got hc %0d m %0b e %0b totals %0d/%0d/%0d",
                              got.hit_count, got.missed, got.evicted,
                              got.hits, got.misses, got.evictions);
                  end
               end
               n_checked++;
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_count <= 0;
         else
            stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic push_access(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] addr);
      access_item_t item;
      item.opcode  = op;
      item.address = addr;
      pending_accesses.push_back(item);
   endtask

   // returns at a rising edge once the unit has nothing left in flight
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_accesses.size() != 0 || req_tvalid || expected_lookups.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // called at a rising edge; leaves csr_valid high
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_SET_BITS:    geo_set_bits    = value[SET_BITS_W-1:0];
         CSR_OFFSET_BITS: geo_offset_bits = value[OFFSET_BITS_W-1:0];
         CSR_WAYS:        geo_ways        = value[WAYS_W-1:0];
         default: ;
      endcase
   endtask

   // unused upper data bits are set at random
   task automatic configure(input int unsigned sbits, input int unsigned obits,
                            input int unsigned ways);
      write_csr(CSR_SET_BITS, CSR_DATA_W'(sbits | ($urandom_range(0, 3) << 3)));
      write_csr(CSR_OFFSET_BITS, CSR_DATA_W'(obits));
      write_csr(CSR_WAYS, CSR_DATA_W'(ways | ($urandom_range(0, 1) << 4)));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // mostly accesses to a small pool of lines so that hits and evictions occur
   task automatic queue_random_phase(input int n);
      bit [63:0] tag_pool[16];
      bit [63:0] addr64;
      int unsigned pool_size;
      int unsigned set_span;
      int unsigned shift;
      int unsigned r;
      logic [OPCODE_W-1:0] op;
      pool_size = active_ways() + $urandom_range(0, 4);
      set_span  = (active_set_bits() >= 2) ? $urandom_range(1, 4) : (1 << active_set_bits());
      shift     = geo_offset_bits + active_set_bits();
      foreach (tag_pool[i]) tag_pool[i] = 64'($urandom);
      for (int i = 0; i < n; i++) begin
         r  = $urandom_range(0, 19);
         op = (r < 19) ? OPCODE_W'(r % 3) : OP_NOP;
         if ($urandom_range(99) < 20) begin
            addr64 = 64'($urandom);
         end else begin
            addr64 = (tag_pool[$urandom_range(0, pool_size - 1)] << shift)
                   | (64'($urandom_range(0, set_span - 1)) << geo_offset_bits)
                   | (64'($urandom) & ((64'd1 << geo_offset_bits) - 64'd1));
         end
         push_access(op, addr64[ADDR_W-1:0]);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: one set, direct mapped, tag is the whole address
      push_access(OP_LOAD,   32'h0000_0000);
      push_access(OP_LOAD,   32'h0000_0000);
      push_access(OP_STORE,  32'h0000_0000);
      push_access(OP_MODIFY, 32'hFFFF_FFFF);
      push_access(OP_LOAD,   32'hFFFF_FFFF);
      push_access(OP_NOP,    32'h0000_0000);
      push_access(OP_NOP,    32'hFFFF_FFFF);
      push_access(OP_STORE,  32'h5555_5555);
      push_access(OP_MODIFY, 32'hAAAA_AAAA);
      push_access(OP_MODIFY, 32'hAAAA_AAAA);
      wait_drained();

      // saturating set bits, ways above the limit, shift past the address width
      write_csr(CSR_UNUSED, 5'h1F);
      configure(7, 31, 15);
      push_access(OP_LOAD,   32'h0000_0000);
      push_access(OP_LOAD,   32'h8000_0000);
      push_access(OP_LOAD,   32'h7FFF_FFFF);
      push_access(OP_MODIFY, 32'hFFFF_FFFF);
      push_access(OP_STORE,  32'h1234_5678);
      wait_drained();

      // zero ways behaves as direct mapped
      configure(0, 0, 0);
      push_access(OP_LOAD,   32'h0000_0001);
      push_access(OP_LOAD,   32'h0000_0002);
      push_access(OP_MODIFY, 32'h0000_0001);
      push_access(OP_NOP,    32'h0000_0001);
      wait_drained();

      configure(6, 26, 8);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
      configure(2, 4, 4);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
      configure(0, 0, 1);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
      configure(3, 2, 12);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();

      // back-to-back stretch, no gaps on either side
      idle_pct = 0;
      configure(6, 0, 8);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
      idle_pct = 37;

      configure(1, 0, 2);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
      configure(5, 26, 3);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
      configure(4, 8, 7);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
      repeat (2) begin
         configure($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 15));
         queue_random_phase(PHASE_ITEMS);
         wait_drained();
      end
      configure(6, 26, 8);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();

      mismatches += expected_lookups.size();
      $display("%0d accesses checked over %0d cache geometries", n_checked, n_settings);
      $display("shadow totals: %0d hits, %0d misses, %0d evictions, %0d mismatches",
               hit_sum, miss_sum, evict_sum, mismatches);
      if (mismatches == 0 && n_checked == n_sent) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### set_assoc_lru_cache_model_unit.f
hw/rtl/sal_pkg.sv
hw/rtl/sal_ram.sv
hw/rtl/sal_way_cmp.sv
hw/rtl/set_assoc_lru_cache_model_unit.sv
tb/sv/tb_top.sv
